FILE: hdl/adlm_pkg.sv
// ----------------------------------------------------------------------------
// adlm_pkg
// Shared widths, defaults and register codes of the delay line mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adlm_pkg;

  // defaults of the top level parameters
  localparam int RING_DEPTH_DEF    = 2048;
  localparam int FULL_LEVEL_DEF    = 256;
  localparam int CHANNEL_COUNT_DEF = 2;

  // delay distance after reset
  localparam int DELAY_RESET = 1000;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int DIST_W     = 11;
  localparam int LEVEL_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_DISTANCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CH0       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CH1       = 2'd3;

endpackage

FILE: hdl/adlm_ram.sv
// ----------------------------------------------------------------------------
// adlm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/audio_delay_line_mixer.sv
// ----------------------------------------------------------------------------
// audio_delay_line_mixer
// Throughput: one item per cycle unless held by out_ready, RAM clearing or a distance
//   write; with feedback on, an item whose history entry is still being mixed by one
//   of the four items ahead waits for its write-back.
// Reset: clears config, then zeroes all CHANNEL_COUNT*RING_DEPTH history RAM entries
//   with in_ready low. A delay_distance write holds both ports while it is reduced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_delay_line_mixer
  import adlm_pkg::*;
#(
  parameter int RING_DEPTH    = RING_DEPTH_DEF,
  parameter int FULL_LEVEL    = FULL_LEVEL_DEF,
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       channel_sel,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int PosW     = $clog2(RING_DEPTH);
  localparam int MemDepth = CHANNEL_COUNT * RING_DEPTH;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int FW       = $clog2(FULL_LEVEL + 1);
  localparam int AbsW     = SAMPLE_W + 1;
  localparam int MagW     = SAMPLE_W - 1 + FW;
  localparam int RecW     = MagW + 1;
  localparam int QW       = SAMPLE_W;
  localparam int RW       = FW + 1;
  localparam int SumW     = SAMPLE_W + 2;
  localparam int StepW    = 1;
  localparam int RedW     = DIST_W + $clog2(RING_DEPTH + 1);
  localparam int LaneDry  = 0;
  localparam int LaneWet  = 1;

  // floor(2^MagW / FULL_LEVEL): quotient estimate is low by at most one
  localparam logic [RecW-1:0]        Recip     = RecW'((64'd1 << MagW) / FULL_LEVEL);
  localparam logic [PosW-1:0]        DistReset = PosW'(DELAY_RESET % RING_DEPTH);
  localparam logic [FW-1:0]          FullF     = FW'(FULL_LEVEL);
  localparam logic [RW-1:0]          FullR     = RW'(FULL_LEVEL);
  localparam logic signed [SumW-1:0] SatHi     = SumW'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SumW-1:0] SatLo     = SumW'(-(1 << (SAMPLE_W - 1)));
  // floor(2^DIST_W / RING_DEPTH): distance quotient estimate is low by at most one
  localparam logic [DIST_W-1:0]      DistRecip = DIST_W'((1 << DIST_W) / RING_DEPTH);

  function automatic logic [AbsW-1:0] abs_sample(logic signed [SAMPLE_W-1:0] v);
    logic [AbsW-1:0] e;
    e = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [AddrW-1:0] entry_addr(logic c, logic [PosW-1:0] p);
    return c ? (AddrW'(RING_DEPTH) + AddrW'(p)) : AddrW'(p);
  endfunction

  // --------------------------------------------------------------------------
  // configuration and distance reduction
  // --------------------------------------------------------------------------
  logic                 feedback_enable;
  logic [PosW-1:0]      dist_mod;
  logic [LEVEL_W-1:0]   level_ch0;
  logic [LEVEL_W-1:0]   level_ch1;
  logic                 red_busy;
  logic [DIST_W-1:0]    red_rem;
  logic [DIST_W-1:0]    red_q;
  logic [StepW-1:0]     red_step;
  logic [2*DIST_W-1:0]  red_qprod;
  logic [RedW-1:0]      red_back;
  logic [RedW-1:0]      red_ext;
  logic [RedW-1:0]      red_est;
  logic [RedW-1:0]      red_sub;
  logic                 cfg_fire;

  assign cfg_ready = !red_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // delay_distance % RING_DEPTH: reciprocal quotient estimate registered in red_q,
  // then back-multiply and one compare and subtract before dist_mod is written
  assign red_qprod = red_rem * DistRecip;
  assign red_ext   = RedW'(red_rem);
  assign red_back  = RedW'(red_q) * RedW'(RING_DEPTH);
  assign red_est   = red_ext - red_back;
  assign red_sub   = (red_est >= RedW'(RING_DEPTH)) ? (red_est - RedW'(RING_DEPTH))
                   : red_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_enable <= 1'b0;
      dist_mod        <= DistReset;
      level_ch0       <= '0;
      level_ch1       <= '0;
      red_busy        <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_FEEDBACK_ENABLE: feedback_enable <= cfg_data[0];
        REG_DELAY_DISTANCE:  red_busy        <= 1'b1;
        REG_LEVEL_CH0:       level_ch0       <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_CH1:       level_ch1       <= cfg_data[LEVEL_W-1:0];
      endcase
    end else if (red_busy && red_step == '0) begin
      red_busy <= 1'b0;
      dist_mod <= PosW'(red_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_fire) begin
      red_rem  <= cfg_data[DIST_W-1:0];
      red_step <= StepW'(1);
    end else if (red_busy) begin
      red_q    <= red_qprod[2*DIST_W-1:DIST_W];
      red_step <= red_step - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic s1_v, s2_v, s3_v, s4_v;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
  logic clearing;
  logic [AddrW-1:0] clr_cnt;
  logic in_fire;
  logic hazard;

  assign s5_ready = !out_valid || out_ready;
  assign s4_ready = !s4_v || s5_ready;
  assign s3_ready = !s3_v || s4_ready;
  assign s2_ready = !s2_v || s3_ready;
  assign s1_ready = !s1_v || s2_ready;

  assign in_ready = s1_ready && !clearing && !red_busy && !hazard;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // accept: address generation and RAM read
  // --------------------------------------------------------------------------
  logic [PosW-1:0]    wp;
  logic [PosW-1:0]    rp;
  logic               ch;
  logic [LEVEL_W-1:0] level_cur;
  logic [LEVEL_W-1:0] lvl_sat;
  logic [AddrW-1:0]   waddr;
  logic [AddrW-1:0]   raddr;

  assign ch        = (CHANNEL_COUNT > 1) ? channel_sel : 1'b0;
  assign level_cur = ch ? level_ch1 : level_ch0;
  assign lvl_sat   = (32'(level_cur) > 32'(FULL_LEVEL)) ? LEVEL_W'(FULL_LEVEL) : level_cur;
  assign rp        = (wp >= dist_mod) ? (wp - dist_mod)
                   : PosW'(({1'b0, wp} + (PosW + 1)'(RING_DEPTH)) - {1'b0, dist_mod});
  assign waddr     = entry_addr(ch, wp);
  assign raddr     = entry_addr(ch, rp);

  logic [AddrW-1:0] s1_waddr, s2_waddr, s3_waddr, s4_waddr;

  // with feedback, wait until an older item has written the entry back
  assign hazard = feedback_enable &&
                  ((s1_v && s1_waddr == raddr) || (s2_v && s2_waddr == raddr) ||
                   (s3_v && s3_waddr == raddr) || (s4_v && s4_waddr == raddr));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == AddrW'(MemDepth - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (in_fire) begin
        wp <= (wp == PosW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // history RAM
  // --------------------------------------------------------------------------
  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  logic [SAMPLE_W-1:0]        mem_wdata;
  logic [SAMPLE_W-1:0]        rd_data;
  logic signed [SAMPLE_W-1:0] mix;

  always_comb begin
    priority if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (feedback_enable) begin
      mem_we    = s4_v && s5_ready;
      mem_waddr = s4_waddr;
      mem_wdata = mix;
    end else begin
      mem_we    = in_fire;
      mem_waddr = waddr;
      mem_wdata = sample_in;
    end
  end

  adlm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MemDepth)
  ) u_history (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // stage 1: pick delayed sample, form weighted magnitudes
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s1_dry;
  logic [LEVEL_W-1:0]         s1_lvl;
  logic                       s1_fwd;
  logic signed [SAMPLE_W-1:0] delayed;
  logic [AbsW+LEVEL_W-1:0]    prod_dry;
  logic [AbsW+FW-1:0]         prod_wet;
  logic [FW-1:0]              wet_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_ready) begin
      s1_v <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dry   <= sample_in;
      s1_lvl   <= lvl_sat;
      // raw input written this cycle at the read entry: RAM returns old data
      s1_fwd   <= !feedback_enable && (raddr == waddr);
      s1_waddr <= waddr;
    end
  end

  assign delayed  = s1_fwd ? s1_dry : rd_data;
  assign wet_lvl  = FullF - FW'(s1_lvl);
  assign prod_dry = abs_sample(s1_dry) * s1_lvl;
  assign prod_wet = abs_sample(delayed) * wet_lvl;

  // --------------------------------------------------------------------------
  // stage 2: quotient estimate by reciprocal
  // --------------------------------------------------------------------------
  logic [MagW-1:0]      s2_mag [2];
  logic                 s2_neg [2];
  logic [MagW+RecW-1:0] rec_prod [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_ready) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v) begin
      s2_mag[LaneDry] <= MagW'(prod_dry);
      s2_mag[LaneWet] <= MagW'(prod_wet);
      s2_neg[LaneDry] <= s1_dry[SAMPLE_W-1];
      s2_neg[LaneWet] <= delayed[SAMPLE_W-1];
      s2_waddr        <= s1_waddr;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rec_prod[i] = s2_mag[i] * Recip;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: remainder of the estimate
  // --------------------------------------------------------------------------
  logic [MagW-1:0] s3_mag [2];
  logic [QW-1:0]   s3_q0 [2];
  logic            s3_neg [2];
  logic [QW+FW-1:0] back_prod [2];
  logic [RW-1:0]   rem [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_ready) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_v) begin
      for (int i = 0; i < 2; i++) begin
        s3_mag[i] <= s2_mag[i];
        s3_q0[i]  <= rec_prod[i][MagW +: QW];
        s3_neg[i] <= s2_neg[i];
      end
      s3_waddr <= s2_waddr;
    end
  end

  // remainder lies below twice the full level, so the low bits suffice
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      back_prod[i] = s3_q0[i] * FullF;
      rem[i]       = s3_mag[i][RW-1:0] - back_prod[i][RW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: correct quotients, restore signs, sum and saturate
  // --------------------------------------------------------------------------
  logic [QW-1:0]          s4_q0 [2];
  logic [RW-1:0]          s4_rem [2];
  logic                   s4_neg [2];
  logic [QW-1:0]          quot [2];
  logic signed [SumW-1:0] term [2];
  logic signed [SumW-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (s4_ready) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_v) begin
      for (int i = 0; i < 2; i++) begin
        s4_q0[i]  <= s3_q0[i];
        s4_rem[i] <= rem[i];
        s4_neg[i] <= s3_neg[i];
      end
      s4_waddr <= s3_waddr;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      quot[i] = s4_q0[i] + QW'(s4_rem[i] >= FullR);
      term[i] = s4_neg[i] ? -$signed(SumW'(quot[i])) : $signed(SumW'(quot[i]));
    end
    sum = term[LaneDry] + term[LaneWet];
    if (sum > SatHi) begin
      mix = SAMPLE_W'(SatHi);
    end else if (sum < SatLo) begin
      mix = SAMPLE_W'(SatLo);
    end else begin
      mix = SAMPLE_W'(sum);
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s5_ready) begin
      out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_ready && s4_v) begin
      sample_out <= mix;
    end
  end

endmodule

FILE: hdl/adlm_checker.sv
// ----------------------------------------------------------------------------
// adlm_checker
// Port-level checks of the delay line mixer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adlm_checker
  import adlm_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [CFG_IDX_W-1:0]       cfg_index,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample_out
);

  // items accepted and not yet delivered
  logic [2:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result changed or dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken while history is being cleared");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 3'd0)
    else $error("result without an accepted item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd5)
    else $error("more items in flight than pipeline stages");

  a_reduce_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_DELAY_DISTANCE |=> !in_ready && !cfg_ready)
    else $error("ports open while delay distance is reduced");

endmodule

bind audio_delay_line_mixer adlm_checker u_adlm_checker (.*);

FILE: tb/audio_delay_line_mixer_tb.sv
// ----------------------------------------------------------------------------
// audio_delay_line_mixer_tb
// Self-checking bench for the delay line mixer. A short table of directed
// samples and register writes runs first, then seven random phases with
// different feedback, distance and level settings. Every accepted sample is
// run through a behavioral echo model kept in the bench, and each result is
// compared in order against the model, or against the row's own value where one is typed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_delay_line_mixer_tb;
  import adlm_pkg::*;

  localparam int N_DIR          = 28;
  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 86;
  localparam int HOLD_OFF_LEN   = 120;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 20;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    int                   reg_val;
    int                   smp;
    logic                 chan;
    bit                   typed;
    int                   want;
  } dir_row_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index   = REG_FEEDBACK_ENABLE;
  logic [CFG_DATA_W-1:0]      cfg_data    = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in   = '0;
  logic                       channel_sel = 1'b0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;

  // echo model state and register shadow
  logic signed [SAMPLE_W-1:0] echo_hist [CHANNEL_COUNT_DEF][RING_DEPTH_DEF];
  logic [DIST_W-1:0]          wr_pos      = '0;
  logic                       fb_r        = 1'b0;
  logic [DIST_W-1:0]          delay_r     = DIST_W'(DELAY_RESET);
  logic [LEVEL_W-1:0]         level_ch0_r = '0;
  logic [LEVEL_W-1:0]         level_ch1_r = '0;

  logic signed [SAMPLE_W-1:0] expected_mix_q [$];

  dir_row_t dir_rows [N_DIR];
  int  mismatches   = 0;
  int  items_in     = 0;
  int  reg_writes   = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  bit  calm         = 1'b0;
  bit  held_once    = 1'b0;

  audio_delay_line_mixer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .channel_sel (channel_sel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 30) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  // advance the echo model by one sample and return the mixed value
  function automatic logic signed [SAMPLE_W-1:0] compute_echo_mix(
      input logic signed [SAMPLE_W-1:0] dry, input logic ch);
    int               lvl;
    int               delayed;
    int               mix;
    logic [DIST_W-1:0] rd_pos;
    lvl = ch ? int'(level_ch1_r) : int'(level_ch0_r);
    if (lvl > FULL_LEVEL_DEF) begin
      lvl = FULL_LEVEL_DEF;
    end
    rd_pos = wr_pos - delay_r;
    // without feedback the raw sample lands before the read
    if (!fb_r) begin
      echo_hist[ch][wr_pos] = dry;
    end
    delayed = echo_hist[ch][rd_pos];
    mix = (int'(dry) * lvl) / FULL_LEVEL_DEF
        + (delayed * (FULL_LEVEL_DEF - lvl)) / FULL_LEVEL_DEF;
    if (mix > 32767) begin
      mix = 32767;
    end else if (mix < -32768) begin
      mix = -32768;
    end
    if (fb_r) begin
      echo_hist[ch][wr_pos] = mix[SAMPLE_W-1:0];
    end
    wr_pos = wr_pos + 1'b1;
    return mix[SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic ch,
                             input bit typed, input int want);
    logic signed [SAMPLE_W-1:0] predicted;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= s;
    channel_sel <= ch;
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    predicted = compute_echo_mix(s, ch);
    expected_mix_q.push_back(typed ? want[SAMPLE_W-1:0] : predicted);
    items_in++;
  endtask

  // hold the input and wait until every result has come back
  task automatic drain_pending();
    in_valid <= 1'b0;
    while (expected_mix_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (cfg_ready !== 1'b1) begin
      @(posedge clk);
    end
    case (idx)
      REG_FEEDBACK_ENABLE: fb_r        = val[0];
      REG_DELAY_DISTANCE:  delay_r     = val[DIST_W-1:0];
      REG_LEVEL_CH0:       level_ch0_r = val[LEVEL_W-1:0];
      REG_LEVEL_CH1:       level_ch1_r = val[LEVEL_W-1:0];
      default: ;
    endcase
    reg_writes++;
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // receiver: random stalls, one long hold-off to back up the pipeline
  initial begin
    forever begin
      @(posedge clk);
      if (!held_once && items_in >= 200) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_mix_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", sample_out));
      end else begin
        want = expected_mix_q.pop_front();
        if (sample_out !== want) begin
          report_mismatch($sformatf("result %0d: sample_out %0d, want %0d",
                                    results_seen, sample_out, want));
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               stall_cycles, expected_mix_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit last;
    int fb_v;
    int dist_v;
    int l0_v;
    int l1_v;
    int smp_v;
    int pick;

    for (int c = 0; c < CHANNEL_COUNT_DEF; c++) begin
      for (int i = 0; i < RING_DEPTH_DEF; i++) begin
        echo_hist[c][i] = '0;
      end
    end

    dir_rows = '{
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,  32767, 1'b0, 1'b1, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0, -32768, 1'b1, 1'b1, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,      1, 1'b0, 1'b1, 0},
      '{ROW_REG,    REG_LEVEL_CH0,     256,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,  32767, 1'b0, 1'b1, 32767},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0, -32768, 1'b0, 1'b1, -32768},
      // level above full saturates: pure dry
      '{ROW_REG,    REG_LEVEL_CH1,     511,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,     -1, 1'b1, 1'b1, -1},
      // zero distance without feedback reads back the current sample
      '{ROW_REG,    REG_DELAY_DISTANCE,  0,      0, 1'b0, 1'b0, 0},
      '{ROW_REG,    REG_LEVEL_CH0,       0,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,  12345, 1'b0, 1'b1, 12345},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0, -32768, 1'b0, 1'b1, -32768},
      // with feedback the same distance reads the old entry
      '{ROW_REG,    REG_FEEDBACK_ENABLE, 1,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,    100, 1'b0, 1'b0, 0},
      '{ROW_REG,    REG_DELAY_DISTANCE,  1,      0, 1'b0, 1'b0, 0},
      '{ROW_REG,    REG_LEVEL_CH0,     128,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,  32767, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,  32767, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0, -32768, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0, -32767, 1'b1, 1'b0, 0},
      '{ROW_REG,    REG_DELAY_DISTANCE, 2047,    0, 1'b0, 1'b0, 0},
      '{ROW_REG,    REG_LEVEL_CH1,       1,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0, -32768, 1'b1, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,  32767, 1'b1, 1'b0, 0},
      '{ROW_REG,    REG_FEEDBACK_ENABLE, 0,      0, 1'b0, 1'b0, 0},
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,      5, 1'b0, 1'b0, 0},
      '{ROW_REG,    REG_DELAY_DISTANCE,  2,      0, 1'b0, 1'b0, 0},
      // small negative product truncates toward zero
      '{ROW_SAMPLE, REG_FEEDBACK_ENABLE, 0,     -3, 1'b1, 1'b0, 0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_REG) begin
        drain_pending();
        last = (r == N_DIR - 1) || (dir_rows[r + 1].kind != ROW_REG);
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val, last);
      end else begin
        send_sample(dir_rows[r].smp[SAMPLE_W-1:0], dir_rows[r].chan,
                    dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          fb_v = 0; dist_v = DELAY_RESET;
          l0_v = $urandom_range(1, 255); l1_v = $urandom_range(1, 255);
        end
        1: begin
          fb_v = 1; dist_v = 1; l0_v = 0; l1_v = FULL_LEVEL_DEF;
        end
        2: begin
          fb_v = 1; dist_v = $urandom_range(2, 5);
          l0_v = 128; l1_v = $urandom_range(257, 511);
        end
        3: begin
          fb_v = 0; dist_v = 2047; l0_v = FULL_LEVEL_DEF; l1_v = 0;
        end
        4: begin
          fb_v = 1; dist_v = 0;
          l0_v = $urandom_range(0, 256); l1_v = $urandom_range(0, 256);
        end
        5: begin
          fb_v = 0; dist_v = $urandom_range(1, 2047);
          l0_v = $urandom_range(0, 511); l1_v = $urandom_range(0, 511);
        end
        default: begin
          // full-width data: the block keeps only the register's own bits
          fb_v = $urandom_range(0, 2047) | 1; dist_v = $urandom_range(1, 8);
          l0_v = $urandom_range(0, 2047); l1_v = $urandom_range(0, 2047);
        end
      endcase
      calm = (ph == 3);
      drain_pending();
      write_reg(REG_FEEDBACK_ENABLE, fb_v, 1'b0);
      write_reg(REG_DELAY_DISTANCE, dist_v, 1'b0);
      write_reg(REG_LEVEL_CH0, l0_v, 1'b0);
      write_reg(REG_LEVEL_CH1, l1_v, 1'b1);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          smp_v = $urandom();
        end else if (pick < 85) begin
          case ($urandom_range(0, 3))
            0: smp_v = 32767;
            1: smp_v = -32768;
            2: smp_v = 0;
            default: smp_v = -1;
          endcase
        end else begin
          smp_v = $urandom_range(0, 600) - 300;
        end
        send_sample(smp_v[SAMPLE_W-1:0], 1'($urandom_range(0, 1)), 1'b0, 0);
      end
    end
    calm = 1'b0;

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_mix_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_mix_q.size()));
    end

    $display("Covered %0d samples and %0d register writes over %0d setting phases,",
             items_in, reg_writes, N_PHASES);
    $display("with and without feedback, distances 0 to 2047, levels up to saturation.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
